[rtl/swmax_pkg.sv]
package swmax_pkg;

  // Field widths fixed by the stream format.
  localparam int DATA_W = 32;
  localparam int POS_W  = 16;
  localparam int CFG_W  = 7;

  // Default queue depth and the window size after reset.
  localparam int MAX_WINDOW_DEF = 64;
  localparam logic [CFG_W-1:0] WINDOW_RESET = CFG_W'(3);

  // One input transaction.
  typedef struct packed {
    logic signed [DATA_W-1:0] sample_value;
    logic                     start_flag;
    logic                     last_flag;
  } in_t;

  // One result transaction.
  typedef struct packed {
    logic signed [DATA_W-1:0] window_max;
    logic                     last_out;
  } out_t;

  // One queue entry: candidate value and its stream position.
  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic [POS_W-1:0]         pos;
  } entry_t;

endpackage

[rtl/sliding_window_maximum_top.sv]
// Sliding window maximum over a stream of signed 32-bit samples.
// Input channel in_valid/in_stall/in_data carries one sample with its start
// and last flags; a start flag clears the queue before the sample is taken.
// Result channel out_valid/out_stall/out_data carries the maximum of the last
// window_size samples once that many samples of the sequence have arrived,
// with the last flag of the sample that made it. The window size is written
// through cfg_wr_en/cfg_wr_data; the user must write it only while the block
// is idle, as the block does not enforce this. The candidate queue lives in
// one memory used as a ring, read through a registered read port. Each
// sample passes the front reads and checks, the back reads and checks, the
// push and the result step, with one read and one check for every entry
// that leaves the front or the back. When the queue runs empty the remaining
// checks are skipped and the sample goes to the push. The input stays stalled
// until its result is registered and can be accepted in the cycle after that.
// A sample whose result finds the output register held by a stalled result
// waits, and the input stays stalled with it. Synchronous reset (rst_n low)
// empties the queue, clears position and fill count, drops any pending
// result and sets the window size to 3. The memory itself is not cleared;
// entries are read only after they were written.
module sliding_window_maximum_top
  import swmax_pkg::*;
#(
  parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_t              in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output out_t             out_data,
  input  logic             cfg_wr_en,
  input  logic [CFG_W-1:0] cfg_wr_data
);

  localparam int AW = $clog2(MAX_WINDOW);
  localparam int CW = $clog2(MAX_WINDOW + 1);
  localparam int SW = CW + 1;
  localparam logic [AW-1:0]    LAST_IDX = AW'(MAX_WINDOW - 1);
  localparam logic [CW-1:0]    MAX_CNT  = CW'(MAX_WINDOW);
  localparam logic [SW-1:0]    MAX_SUM  = SW'(MAX_WINDOW);
  localparam logic [POS_W-1:0] MAX_POS  = POS_W'(MAX_WINDOW);

  // Sequencer states.
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_FRD  = 3'd1;
  localparam logic [2:0] S_FCHK = 3'd2;
  localparam logic [2:0] S_BRD  = 3'd3;
  localparam logic [2:0] S_BCHK = 3'd4;
  localparam logic [2:0] S_PUSH = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [2:0]       state_r, state_nxt;
  logic [AW-1:0]    head_r, head_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [CW-1:0]    filled_r, filled_nxt;
  logic [CFG_W-1:0] ws_r;
  logic signed [DATA_W-1:0] smp_r, smp_nxt;
  logic             last_r, last_nxt;
  logic             fwd_r, fwd_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_t             out_data_r, out_data_nxt;

  // Memory ports.
  entry_t           mem [MAX_WINDOW];
  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  entry_t           rd_q_r;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  entry_t           wr_data;

  // Helper values.
  logic [POS_W-1:0] k_eff;
  logic [POS_W-1:0] ws_ext;
  logic [POS_W-1:0] pos_gap;
  logic [AW-1:0]    head_inc;
  logic [SW-1:0]    back_sum;
  logic [AW-1:0]    back_addr;
  logic             drop;
  logic [AW-1:0]    head_p;
  logic [CW-1:0]    count_p;
  logic [SW-1:0]    push_sum;
  logic [AW-1:0]    push_addr;
  logic             in_accept;
  logic             out_free;
  logic signed [DATA_W-1:0] front_val;

  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || !out_stall;

  // Effective window: zero counts as one, sizes above the depth are clamped.
  assign ws_ext = POS_W'(ws_r);
  always_comb begin
    if (ws_r == '0) begin
      k_eff = POS_W'(1);
    end else if (ws_ext > MAX_POS) begin
      k_eff = MAX_POS;
    end else begin
      k_eff = ws_ext;
    end
  end

  // Ring pointer arithmetic.
  assign head_inc  = (head_r == LAST_IDX) ? '0 : head_r + AW'(1);
  assign back_sum  = SW'(head_r) + SW'(count_r) - SW'(1);
  assign back_addr = (back_sum >= MAX_SUM) ? AW'(back_sum - MAX_SUM) : AW'(back_sum);
  assign drop      = (count_r == MAX_CNT);
  assign head_p    = drop ? head_inc : head_r;
  assign count_p   = drop ? count_r - CW'(1) : count_r;
  assign push_sum  = SW'(head_p) + SW'(count_p);
  assign push_addr = (push_sum >= MAX_SUM) ? AW'(push_sum - MAX_SUM) : AW'(push_sum);

  assign pos_gap   = pos_r - rd_q_r.pos;
  assign front_val = fwd_r ? smp_r : rd_q_r.value;

  // Sequencer: front eviction, back eviction, push, then result.
  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    count_nxt     = count_r;
    pos_nxt       = pos_r;
    filled_nxt    = filled_r;
    smp_nxt       = smp_r;
    last_nxt      = last_r;
    fwd_nxt       = fwd_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    rd_en         = 1'b0;
    rd_addr       = head_r;
    wr_en         = 1'b0;
    wr_addr       = push_addr;
    wr_data.value = smp_r;
    wr_data.pos   = pos_r;

    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          smp_nxt  = in_data.sample_value;
          last_nxt = in_data.last_flag;
          if (in_data.start_flag) begin
            count_nxt  = '0;
            pos_nxt    = '0;
            filled_nxt = '0;
          end
          state_nxt = S_FRD;
        end
      end
      S_FRD: begin
        if (count_r == '0) begin
          state_nxt = S_PUSH;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = head_r;
          state_nxt = S_FCHK;
        end
      end
      S_FCHK: begin
        // The front entry leaves when its position is outside the window.
        if (pos_gap >= k_eff) begin
          head_nxt  = head_inc;
          count_nxt = count_r - CW'(1);
          state_nxt = S_FRD;
        end else begin
          state_nxt = S_BRD;
        end
      end
      S_BRD: begin
        if (count_r == '0) begin
          state_nxt = S_PUSH;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = back_addr;
          state_nxt = S_BCHK;
        end
      end
      S_BCHK: begin
        // Strictly smaller entries leave the back; equal ones stay.
        if (rd_q_r.value < smp_r) begin
          count_nxt = count_r - CW'(1);
          state_nxt = S_BRD;
        end else begin
          state_nxt = S_PUSH;
        end
      end
      S_PUSH: begin
        // Append the sample and fetch the new front for the result.
        wr_en      = 1'b1;
        head_nxt   = head_p;
        count_nxt  = count_p + CW'(1);
        rd_en      = 1'b1;
        rd_addr    = head_p;
        fwd_nxt    = (count_p == '0);
        pos_nxt    = pos_r + POS_W'(1);
        if (filled_r != MAX_CNT) begin
          filled_nxt = filled_r + CW'(1);
        end
        state_nxt  = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          if (POS_W'(filled_r) >= k_eff) begin
            out_valid_nxt         = 1'b1;
            out_data_nxt.window_max = front_val;
            out_data_nxt.last_out   = last_r;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control and payload registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      pos_r       <= '0;
      filled_r    <= '0;
      fwd_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      pos_r       <= pos_nxt;
      filled_r    <= filled_nxt;
      fwd_r       <= fwd_nxt;
      out_valid_r <= out_valid_nxt;
    end
    smp_r      <= smp_nxt;
    last_r     <= last_nxt;
    out_data_r <= out_data_nxt;
  end

  // Window size register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ws_r <= WINDOW_RESET;
    end else if (cfg_wr_en) begin
      ws_r <= cfg_wr_data;
    end
  end

  // Queue memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
  end

endmodule
